@@ rtl/core/aldbr_pkg.sv @@
// Package for the ladder keypad debounce block: widths, register indexes, reset values, button codes, phase type.
package aldbr_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int THR_W           = 10;
    localparam int TICK_W          = 16;
    localparam int CODE_W          = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THR_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR_FIVE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd7;

    // reset values
    localparam logic [THR_W-1:0]  RST_THR_ONE   = 10'd102;
    localparam logic [THR_W-1:0]  RST_THR_TWO   = 10'd306;
    localparam logic [THR_W-1:0]  RST_THR_THREE = 10'd510;
    localparam logic [THR_W-1:0]  RST_THR_FOUR  = 10'd714;
    localparam logic [THR_W-1:0]  RST_THR_FIVE  = 10'd918;
    localparam logic [TICK_W-1:0] RST_FIRST     = 16'd5;
    localparam logic [TICK_W-1:0] RST_LONG      = 16'd100;
    localparam logic [TICK_W-1:0] RST_REPEAT    = 16'd25;

    // button codes
    localparam logic [CODE_W-1:0] CODE_NONE  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ONE   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_TWO   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_THREE = 3'd3;
    localparam logic [CODE_W-1:0] CODE_FOUR  = 3'd4;
    localparam logic [CODE_W-1:0] CODE_FIVE  = 3'd5;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_LONG   = 3'b010,
        PH_REPEAT = 3'b100
    } t_phase;

endpackage

@@ rtl/core/adc_ladder_button_debounce_repeat.sv @@
// Resistor-ladder keypad: sample classification, debounce and auto-repeat.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_adc_sample
//  out     | source    | o_out_valid / i_out_stall  | o_button_code, o_press_event
//  cfg     | sink      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One beat in, one beat out; a beat may enter every cycle while no stall holds the result.
// The sample is captured in the input register, then classification, the hold
// counter update and the event compare run in one pass into the result register.
// The hold state (code, counter, phase) updates when the result register loads.
// Reset (i_rst_n low, synchronous) clears valids, state and loads default registers.
// A stall on the out side holds the result; the input register keeps taking a beat
// as long as the result register can move, so a stalled full output stalls the input.
module adc_ladder_button_debounce_repeat #(
    parameter int SAMPLE_BITS = aldbr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample beats
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [SAMPLE_BITS-1:0]              i_adc_sample,
    // result beats
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [aldbr_pkg::CODE_W-1:0]        o_button_code,
    output logic                                o_press_event,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [aldbr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [aldbr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // compare width covers both the sample and the 10-bit thresholds
    localparam int CmpW = (SAMPLE_BITS > aldbr_pkg::THR_W) ? SAMPLE_BITS : aldbr_pkg::THR_W;

    // configuration registers
    logic [aldbr_pkg::THR_W-1:0]  r_thr_one, r_thr_two, r_thr_three, r_thr_four, r_thr_five;
    logic [aldbr_pkg::TICK_W-1:0] r_first_ticks, r_long_ticks, r_repeat_ticks;

    // pipeline registers
    logic                         r_in_valid;
    logic [SAMPLE_BITS-1:0]       r_in_sample;
    logic                         r_out_valid;
    logic [aldbr_pkg::CODE_W-1:0] r_out_code;
    logic                         r_out_event;

    // hold state
    logic [aldbr_pkg::CODE_W-1:0] r_prev_code;
    logic [aldbr_pkg::TICK_W-1:0] r_hold_count;
    aldbr_pkg::t_phase            r_phase;

    logic [aldbr_pkg::CODE_W-1:0] n_code;
    logic [aldbr_pkg::TICK_W-1:0] n_hold_count;
    aldbr_pkg::t_phase            n_phase;
    logic                         n_event;

    logic [aldbr_pkg::TICK_W-1:0] w_count;
    logic [aldbr_pkg::TICK_W-1:0] w_limit;
    aldbr_pkg::t_phase            w_phase;
    logic [CmpW-1:0]              w_sample;

    logic w_out_load;   // result register takes the stage-one beat
    logic w_in_take;    // input register takes a new beat

    assign w_out_load = r_in_valid && (!r_out_valid || !i_out_stall);
    assign w_in_take  = !r_in_valid || w_out_load;
    assign o_in_stall = !w_in_take;

    // ---- register writes ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_one      <= aldbr_pkg::RST_THR_ONE;
            r_thr_two      <= aldbr_pkg::RST_THR_TWO;
            r_thr_three    <= aldbr_pkg::RST_THR_THREE;
            r_thr_four     <= aldbr_pkg::RST_THR_FOUR;
            r_thr_five     <= aldbr_pkg::RST_THR_FIVE;
            r_first_ticks  <= aldbr_pkg::RST_FIRST;
            r_long_ticks   <= aldbr_pkg::RST_LONG;
            r_repeat_ticks <= aldbr_pkg::RST_REPEAT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aldbr_pkg::REG_THR_ONE:   r_thr_one      <= i_cfg_data[aldbr_pkg::THR_W-1:0];
                aldbr_pkg::REG_THR_TWO:   r_thr_two      <= i_cfg_data[aldbr_pkg::THR_W-1:0];
                aldbr_pkg::REG_THR_THREE: r_thr_three    <= i_cfg_data[aldbr_pkg::THR_W-1:0];
                aldbr_pkg::REG_THR_FOUR:  r_thr_four     <= i_cfg_data[aldbr_pkg::THR_W-1:0];
                aldbr_pkg::REG_THR_FIVE:  r_thr_five     <= i_cfg_data[aldbr_pkg::THR_W-1:0];
                aldbr_pkg::REG_FIRST:     r_first_ticks  <= i_cfg_data;
                aldbr_pkg::REG_LONG:      r_long_ticks   <= i_cfg_data;
                aldbr_pkg::REG_REPEAT:    r_repeat_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- classify: highest threshold checked first, first exceeded wins ----
    assign w_sample = CmpW'(r_in_sample);

    always_comb begin
        if (w_sample > CmpW'(r_thr_five))       n_code = aldbr_pkg::CODE_FIVE;
        else if (w_sample > CmpW'(r_thr_four))  n_code = aldbr_pkg::CODE_FOUR;
        else if (w_sample > CmpW'(r_thr_three)) n_code = aldbr_pkg::CODE_THREE;
        else if (w_sample > CmpW'(r_thr_two))   n_code = aldbr_pkg::CODE_TWO;
        else if (w_sample > CmpW'(r_thr_one))   n_code = aldbr_pkg::CODE_ONE;
        else                                    n_code = aldbr_pkg::CODE_NONE;
    end

    // ---- hold counter and phase ----
    always_comb begin
        // same code: saturating count; new code: restart debounce
        if (n_code == r_prev_code) begin
            w_count = (r_hold_count == aldbr_pkg::TICK_MAX) ? r_hold_count
                                                            : r_hold_count + 1'b1;
            w_phase = r_phase;
        end else begin
            w_count = '0;
            w_phase = aldbr_pkg::PH_FIRST;
        end

        case (w_phase)
            aldbr_pkg::PH_FIRST: w_limit = r_first_ticks;
            aldbr_pkg::PH_LONG:  w_limit = r_long_ticks;
            default:             w_limit = r_repeat_ticks;
        endcase

        // zero hold time fires on entry since the test is >=
        n_event = (w_count >= w_limit);
        if (n_event) begin
            n_hold_count = '0;
            case (w_phase)
                aldbr_pkg::PH_FIRST: n_phase = aldbr_pkg::PH_LONG;
                default:             n_phase = aldbr_pkg::PH_REPEAT;
            endcase
        end else begin
            n_hold_count = w_count;
            n_phase      = w_phase;
        end
    end

    // ---- pipeline control and state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_code  <= aldbr_pkg::CODE_NONE;
            r_hold_count <= '0;
            r_phase      <= aldbr_pkg::PH_FIRST;
        end else begin
            if (w_in_take) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_load) begin
                r_out_valid  <= 1'b1;
                r_prev_code  <= n_code;
                r_hold_count <= n_hold_count;
                r_phase      <= n_phase;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take && i_in_valid) begin
            r_in_sample <= i_adc_sample;
        end
        if (w_out_load) begin
            r_out_code  <= n_code;
            r_out_event <= n_event;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_button_code = r_out_code;
    assign o_press_event = r_out_event;

endmodule
